// File: hdl/btc_pkg.sv
// ----------------------------------------------------------------------------
// btc_pkg: shared definitions for the block transposition encryptor
// Key layout, register map, controller states and the command/status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package btc_pkg;

    // Block geometry default
    localparam int BLOCK_BYTES_DEF = 6;

    // Packed key: one source position per output slot, slot 0 lowest
    localparam int SLOT_BITS  = 3;
    localparam int PERM_W     = 18;
    localparam int PERM_SLOTS = PERM_W / SLOT_BITS;
    localparam int SLOT_IDX_W = $clog2(PERM_SLOTS);

    localparam logic [PERM_W-1:0] PERM_RESET = 18'd181896;
    localparam logic [7:0]        PAD_RESET  = 8'h78;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from the word address
    typedef enum logic {
        REG_PERMUTATION = 1'b0,
        REG_PAD_BYTE    = 1'b1
    } t_reg_idx;

    // Controller states
    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } t_state;

    // Configuration values handed to the datapath
    typedef struct packed {
        logic [PERM_W-1:0] perm;
        logic [7:0]        pad;
    } t_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic store_wr;  // write accepted byte at the fill position
        logic load;      // load output register with the current slot
        logic blk_clr;   // block done: clear fill count and slot index
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic blk_done;  // byte on the input completes the block
        logic idx_last;  // slot index points at the last output slot
    } t_dp_sts;

endpackage

// File: hdl/btc_if.sv
// ----------------------------------------------------------------------------
// btc_if: stream channels of the block transposition encryptor
// Plaintext input channel and ciphertext output channel, valid/ready.
// ----------------------------------------------------------------------------
interface btc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface btc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] cipher_byte;
    logic       final_out;

    modport source (output valid, output cipher_byte, output final_out, input ready);
    modport sink   (input valid, input cipher_byte, input final_out, output ready);
endinterface

// File: hdl/btc_regs.sv
// ----------------------------------------------------------------------------
// btc_regs: configuration registers
// APB-style write/read of the packed key and the pad byte.
// ----------------------------------------------------------------------------
module btc_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [btc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [btc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [btc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output btc_pkg::t_cfg                    o_cfg
);

    logic [btc_pkg::PERM_W-1:0] r_perm;
    logic [7:0]                 r_pad;
    logic                       w_wr;
    btc_pkg::t_reg_idx          w_idx;

    // Decode the word address; byte offset bits select nothing
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = btc_pkg::t_reg_idx'(paddr[2]);

    // Write registers at the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm <= btc_pkg::PERM_RESET;
            r_pad  <= btc_pkg::PAD_RESET;
        end else if (w_wr) begin
            case (w_idx)
                btc_pkg::REG_PERMUTATION: r_perm <= pwdata[btc_pkg::PERM_W-1:0];
                btc_pkg::REG_PAD_BYTE:    r_pad  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        case (w_idx)
            btc_pkg::REG_PERMUTATION: prdata = btc_pkg::APB_DATA_W'(r_perm);
            btc_pkg::REG_PAD_BYTE:    prdata = btc_pkg::APB_DATA_W'(r_pad);
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg.perm = r_perm;
    assign o_cfg.pad  = r_pad;

endmodule

// File: hdl/btc_ctrl.sv
// ----------------------------------------------------------------------------
// btc_ctrl: block sequencing controller
// Collects bytes until a block completes, then steps through the output
// slots, one transaction per free output register.
// ----------------------------------------------------------------------------
module btc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  btc_pkg::t_dp_sts  i_sts,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output btc_pkg::t_dp_cmd  o_cmd
);

    btc_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_out_free;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= btc_pkg::ST_COLLECT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            btc_pkg::ST_COLLECT: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.store_wr = 1'b1;
                    if (i_sts.blk_done) begin
                        n_state = btc_pkg::ST_EMIT;
                    end
                end
            end
            btc_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_sts.idx_last) begin
                        o_cmd.blk_clr = 1'b1;
                        n_state       = btc_pkg::ST_COLLECT;
                    end
                end
            end
            default: begin
                n_state = btc_pkg::ST_COLLECT;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // A byte that completes the block starts emission
    a_done_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_sts.blk_done) |=> (r_state == btc_pkg::ST_EMIT))
        else $error("block completion did not start emission");

    // A stalled output keeps the controller emitting
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == btc_pkg::ST_EMIT && !w_out_free) |=> (r_state == btc_pkg::ST_EMIT))
        else $error("emission left while output stalled");

    // Every load presents a transaction
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_out_valid)
        else $error("loaded output not marked valid");
`endif

endmodule

// File: hdl/btc_datapath.sv
// ----------------------------------------------------------------------------
// btc_datapath: block store, key lookup and output register
// Holds the collected bytes and selects the byte for each output slot;
// positions past the fill count read as the pad byte.
// ----------------------------------------------------------------------------
module btc_datapath #(
    parameter int BLOCK_BYTES = btc_pkg::BLOCK_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  btc_pkg::t_dp_cmd  i_cmd,
    input  btc_pkg::t_cfg     i_cfg,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_message,
    output btc_pkg::t_dp_sts  o_sts,
    output logic [7:0]        o_cipher_byte,
    output logic              o_final_out
);

    localparam int IDX_W  = $clog2(BLOCK_BYTES);
    localparam int CNT_W  = $clog2(BLOCK_BYTES + 1);
    localparam int MAX_SB = (btc_pkg::SLOT_BITS > btc_pkg::SLOT_IDX_W) ?
                            btc_pkg::SLOT_BITS : btc_pkg::SLOT_IDX_W;
    localparam int CMP_W  = (CNT_W > MAX_SB) ? CNT_W : MAX_SB;

    logic [7:0]                    r_store [BLOCK_BYTES];
    logic [CNT_W-1:0]              r_fill;
    logic [IDX_W-1:0]              r_idx;
    logic                          r_last;
    logic [7:0]                    r_out_byte;
    logic                          r_out_final;

    logic [btc_pkg::SLOT_BITS-1:0] w_slots [btc_pkg::PERM_SLOTS];
    logic [CMP_W-1:0]              w_idx_ext;
    logic [btc_pkg::SLOT_BITS-1:0] w_src;
    logic [CMP_W-1:0]              w_src_ext;
    logic                          w_hit;
    logic [7:0]                    w_byte;

    // Unpack the key into slots
    always_comb begin
        for (int k = 0; k < btc_pkg::PERM_SLOTS; k++) begin
            w_slots[k] = i_cfg.perm[k*btc_pkg::SLOT_BITS +: btc_pkg::SLOT_BITS];
        end
    end

    // Source position of the current slot; slots beyond the key read zero
    assign w_idx_ext = CMP_W'(r_idx);
    assign w_src     = (w_idx_ext < CMP_W'(btc_pkg::PERM_SLOTS)) ?
                       w_slots[w_idx_ext[btc_pkg::SLOT_IDX_W-1:0]] : '0;
    assign w_src_ext = CMP_W'(w_src);

    // Unfilled or out-of-range positions take the pad byte
    assign w_hit  = w_src_ext < CMP_W'(r_fill);
    assign w_byte = w_hit ? r_store[w_src_ext[IDX_W-1:0]] : i_cfg.pad;

    // Status to the controller
    assign o_sts.blk_done = (r_fill == CNT_W'(BLOCK_BYTES - 1)) || i_end_of_message;
    assign o_sts.idx_last = (r_idx == IDX_W'(BLOCK_BYTES - 1));

    // Fill count, slot index and end-of-message flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_idx  <= '0;
            r_last <= 1'b0;
        end else begin
            if (i_cmd.blk_clr) begin
                r_fill <= '0;
                r_idx  <= '0;
            end else begin
                if (i_cmd.store_wr) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
                if (i_cmd.load) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            if (i_cmd.store_wr) begin
                r_last <= i_end_of_message;
            end
        end
    end

    // Block store and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr) begin
            r_store[r_fill[IDX_W-1:0]] <= i_data_byte;
        end
        if (i_cmd.load) begin
            r_out_byte  <= w_byte;
            r_out_final <= r_last && o_sts.idx_last;
        end
    end

    assign o_cipher_byte = r_out_byte;
    assign o_final_out   = r_out_final;

`ifndef NO_ASSERTIONS
    // Fill count stays within the block
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(BLOCK_BYTES))
        else $error("fill count beyond block size");

    // Emission only of a block that holds data
    a_load_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (r_fill != '0))
        else $error("output loaded from an empty block");

    // Final mark only on the last slot
    a_final_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && !o_sts.idx_last) |=> !r_out_final)
        else $error("final mark on a slot other than the last");
`endif

endmodule

// File: hdl/block_transposition_encrypt_core.sv
// ----------------------------------------------------------------------------
// block_transposition_encrypt_core: block transposition encryptor
// Collects plaintext bytes into blocks and emits each block permuted by the
// configured key, padding an incomplete final block.
//
//   Channel   Dir   Handshake        Payload
//   i_in_ch   in    valid/ready      data_byte[7:0], end_of_message
//   o_out_ch  out   valid/ready      cipher_byte[7:0], final_out
//   apb       in    psel/penable     paddr[2:0], pwdata[31:0], prdata[31:0]
//
// A block is collected one byte a cycle while input is valid, then the controller
// steps the BLOCK_BYTES output slots through the key lookup, loading one slot
// each time the output register is free; input is held off while the slots are
// emitted, and a stalled output holds the emission in place.
// The next block's first byte is taken while the last cipher byte still waits.
// Reset is synchronous, active low, and restores the identity key and 'x' pad.
// ----------------------------------------------------------------------------
module block_transposition_encrypt_core #(
    parameter int BLOCK_BYTES = btc_pkg::BLOCK_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    btc_in_if.sink                           i_in_ch,
    btc_out_if.source                        o_out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [btc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [btc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [btc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    btc_pkg::t_cfg    w_cfg;
    btc_pkg::t_dp_cmd w_cmd;
    btc_pkg::t_dp_sts w_sts;
    logic             w_in_ready;
    logic             w_out_valid;
    logic [7:0]       w_cipher_byte;
    logic             w_final_out;

    // Configuration registers
    btc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Controller
    btc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .i_sts       (w_sts),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    // Datapath
    btc_datapath #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg            (w_cfg),
        .i_data_byte      (i_in_ch.data_byte),
        .i_end_of_message (i_in_ch.end_of_message),
        .o_sts            (w_sts),
        .o_cipher_byte    (w_cipher_byte),
        .o_final_out      (w_final_out)
    );

    // Drive the channels
    assign i_in_ch.ready        = w_in_ready;
    assign o_out_ch.valid       = w_out_valid;
    assign o_out_ch.cipher_byte = w_cipher_byte;
    assign o_out_ch.final_out   = w_final_out;

endmodule

// File: dv/block_transposition_encrypt_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_transposition_encrypt_core_tb: self-checking bench for the encryptor
// Streams plaintext messages into the core, predicts every cipher byte from
// its own copy of the key, pad byte and block buffer, and checks each output
// transaction in order. Covers the reset key, extreme and out-of-range keys,
// padded and unpadded final blocks, then random keys and messages under
// random idling on both channels.
// ----------------------------------------------------------------------------
module block_transposition_encrypt_core_tb;

    localparam int BLK           = btc_pkg::BLOCK_BYTES_DEF;
    localparam int SETTLE_CYCLES = 4 * BLK;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PCT      = 14;

    typedef struct {
        logic [7:0] cipher_byte;
        logic       final_out;
    } t_cipher_exp;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [btc_pkg::APB_ADDR_W-1:0] paddr;
    logic [btc_pkg::APB_DATA_W-1:0] pwdata;
    logic [btc_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    btc_in_if  in_ch ();
    btc_out_if out_ch ();

    block_transposition_encrypt_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predictor state: key, pad byte, block buffer and fill position
    logic [btc_pkg::PERM_W-1:0] key_perm;
    logic [7:0]                 key_pad;
    logic [7:0]                 plain_blk [BLK];
    int                         plain_fill;

    t_cipher_exp expected_cipher_q [$];
    t_cipher_exp oldest;

    int  n_errors;
    int  n_cycles;
    bit  src_gaps;
    bit  snk_gaps;

    // Toggle the clock every half period
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stall the output channel at random
    always @(negedge i_clk) begin
        out_ch.ready <= snk_gaps ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end

    // Check each output transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_cipher_q.size() == 0) begin
                $error("unexpected cipher_byte %02h final_out %0b",
                       out_ch.cipher_byte, out_ch.final_out);
                n_errors++;
            end else begin
                oldest = expected_cipher_q.pop_front();
                if (out_ch.cipher_byte !== oldest.cipher_byte) begin
                    $error("cipher_byte: expected %02h, got %02h",
                           oldest.cipher_byte, out_ch.cipher_byte);
                    n_errors++;
                end
                if (out_ch.final_out !== oldest.final_out) begin
                    $error("final_out: expected %0b, got %0b",
                           oldest.final_out, out_ch.final_out);
                    n_errors++;
                end
            end
        end
    end

    // Collect one plaintext byte; on a full block or end mark, queue the cipher bytes
    function automatic void encrypt_byte(input logic [7:0] b, input logic eom);
        logic [btc_pkg::SLOT_BITS-1:0] src;
        t_cipher_exp                   c;
        plain_blk[plain_fill] = b;
        plain_fill++;
        if (plain_fill < BLK && !eom) return;
        for (int j = plain_fill; j < BLK; j++) plain_blk[j] = key_pad;
        for (int j = 0; j < BLK; j++) begin
            src           = key_perm[j*btc_pkg::SLOT_BITS +: btc_pkg::SLOT_BITS];
            c.cipher_byte = (src < BLK) ? plain_blk[src] : key_pad;
            c.final_out   = eom && (j == BLK - 1);
            expected_cipher_q.push_back(c);
        end
        plain_fill = 0;
    endfunction

    // Draw a key: mostly true permutations, sometimes arbitrary slot values
    function automatic logic [btc_pkg::PERM_W-1:0] random_key();
        int                         order [BLK];
        int                         k;
        int                         tmp;
        logic [btc_pkg::PERM_W-1:0] key;
        if ($urandom_range(9) >= 7) return btc_pkg::PERM_W'($urandom);
        for (int i = 0; i < BLK; i++) order[i] = i;
        for (int i = BLK - 1; i > 0; i--) begin
            k        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[k];
            order[k] = tmp;
        end
        key = '0;
        for (int i = 0; i < BLK; i++) begin
            key[i*btc_pkg::SLOT_BITS +: btc_pkg::SLOT_BITS] =
                btc_pkg::SLOT_BITS'(order[i]);
        end
        return key;
    endfunction

    // Send one byte; called and returning at a falling edge, valid left as is
    task automatic send_byte(input logic [7:0] b, input logic eom);
        while (src_gaps && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= b;
        in_ch.end_of_message <= eom;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        encrypt_byte(b, eom);
        @(negedge i_clk);
    endtask

    // Hold off the input until every queued cipher byte has come out
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (expected_cipher_q.size() != 0) @(negedge i_clk);
    endtask

    // Drain, then let the core settle so it is idle
    task automatic drain_and_settle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One APB write: setup cycle, then access cycle
    task automatic apb_write(input btc_pkg::t_reg_idx idx,
                             input logic [btc_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= btc_pkg::APB_ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            btc_pkg::REG_PERMUTATION: begin
                key_perm = value[btc_pkg::PERM_W-1:0];
            end
            btc_pkg::REG_PAD_BYTE: begin
                key_pad = value[7:0];
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Reprogram both registers once the core is idle; junk the unused upper bits
    task automatic configure(input logic [btc_pkg::PERM_W-1:0] perm, input logic [7:0] pad);
        drain_and_settle();
        apb_write(btc_pkg::REG_PERMUTATION, btc_pkg::APB_DATA_W'({$urandom, perm}));
        apb_write(btc_pkg::REG_PAD_BYTE, btc_pkg::APB_DATA_W'({$urandom, pad}));
    endtask

    // Reset key: a full block, a padded block and a one-byte message
    task automatic test_reset_key();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h33, 1'b1);
        send_byte(8'hC3, 1'b1);
    endtask

    // All-zero key with end mark on a full block, then all-ones key (every slot padded)
    task automatic test_key_extremes();
        configure('0, 8'h00);
        for (int i = 0; i < BLK; i++) send_byte((i % 2) ? 8'h00 : 8'hFF, i == BLK - 1);
        configure('1, 8'hFF);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
    endtask

    // Key mixing out-of-range slots with real ones, on a padded final block
    task automatic test_out_of_range_slots();
        configure({3'd0, 3'd2, 3'd3, 3'd7, 3'd5, 3'd6}, 8'hA5);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(8'h88, 1'b0);
        send_byte(8'hF0, 1'b1);
    endtask

    // Reset key and pad, then random per phase; random messages; one phase not idled
    task automatic test_random_messages();
        int                         msg_len;
        int                         msg_idx;
        int                         phase_sent;
        logic [btc_pkg::PERM_W-1:0] perm;
        logic [7:0]                 pad;
        msg_idx = 0;
        for (int phase = 0; phase < 6; phase++) begin
            perm = random_key();
            pad  = 8'($urandom);
            if (phase == 0) begin
                perm = btc_pkg::PERM_RESET;
                pad  = btc_pkg::PAD_RESET;
            end
            configure(perm, pad);
            src_gaps   = (phase != 3);
            snk_gaps   = (phase != 3);
            phase_sent = 0;
            while (phase_sent < 45) begin
                if (msg_idx == 2) msg_len = 11;
                else if ($urandom_range(9) < 3) msg_len = BLK * $urandom_range(1, 3);
                else msg_len = $urandom_range(1, 3 * BLK);
                for (int k = 0; k < msg_len; k++) begin
                    send_byte(8'($urandom), k == msg_len - 1);
                    // Pause mid-message until the output has fully drained
                    if (msg_idx == 2 && k == BLK - 1) wait_for_results();
                end
                phase_sent += msg_len;
                msg_idx++;
            end
        end
        src_gaps = 1'b1;
        snk_gaps = 1'b1;
    endtask

    // Reset, run the tests in turn, then report
    initial begin
        n_errors             = 0;
        n_cycles             = 0;
        src_gaps             = 1'b1;
        snk_gaps             = 1'b1;
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_ch.valid          = 1'b0;
        in_ch.data_byte      = '0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready         = 1'b0;
        key_perm             = btc_pkg::PERM_RESET;
        key_pad              = btc_pkg::PAD_RESET;
        plain_fill           = 0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_key();
        test_key_extremes();
        test_out_of_range_slots();
        test_random_messages();

        drain_and_settle();
        if (n_errors == 0 && expected_cipher_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/btc_pkg.sv
hdl/btc_if.sv
hdl/btc_regs.sv
hdl/btc_ctrl.sv
hdl/btc_datapath.sv
hdl/block_transposition_encrypt_core.sv
dv/block_transposition_encrypt_core_tb.sv
